>>> sv/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, encodings and helpers of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam logic [1:0] CTR_STRONG_TAKEN      = 2'd3;
  localparam logic [1:0] CHOOSER_STRONG_GSHARE = 2'd3;
  localparam logic [1:0] CTR_MAX               = 2'd3;
  localparam logic [1:0] CTR_MIN               = 2'd0;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } in_beat_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        prediction_correct;
    logic        used_gshare;
    logic [31:0] correct_count;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } tbp_state_t;

  function automatic logic [1:0] sat_update(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    if (up) begin
      res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
    end else begin
      res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

>>> sv/tbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tournament_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Gshare and bimodal predictors with a per-address chooser, trained by
// resolved branches.
// ----------------------------------------------------------------------------
// After reset the block sweeps all three tables to their initial values, one
// entry per cycle, with busy held high. It then takes one branch at a time and
// holds busy high until it is done: the cycle of acceptance reads the
// gshare memory and the combined bimodal and chooser memory, and the next
// cycle updates the entries and writes them back through the single write
// port of each memory. The result is registered in the update state and
// strobed on out_valid for one cycle, and must be taken in that cycle since
// the block cannot be stalled on its output side.
module tournament_branch_predictor_unit #(
  parameter int INDEX_BITS   = 10,
  parameter int HISTORY_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tbp_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output tbp_pkg::out_beat_t  out_beat
);

  import tbp_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;

  tbp_state_t              state_r, state_nxt;
  logic [INDEX_BITS-1:0]   clr_idx_r, clr_idx_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic [31:0]             hit_r, hit_nxt;
  logic [INDEX_BITS-1:0]   bidx_r, gidx_r;
  logic                    taken_r;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_beat_r, out_beat_nxt;

  logic [INDEX_BITS-1:0]   hist_idx;
  logic [INDEX_BITS-1:0]   bidx_in, gidx_in;
  logic [HISTORY_BITS:0]   hist_shift;
  logic                    accept;

  logic                    g_we, bc_we;
  logic [INDEX_BITS-1:0]   g_waddr, bc_waddr;
  logic [1:0]              g_wdata;
  logic [3:0]              bc_wdata;
  logic [1:0]              g_rdata;
  logic [3:0]              bc_rdata;

  logic                    g_pred, b_pred, g_ok, b_ok, use_g, pred, ok;
  logic [1:0]              ch_new;

  generate
    if (HISTORY_BITS >= INDEX_BITS) begin : g_hist_trunc
      assign hist_idx = hist_r[INDEX_BITS-1:0];
    end else begin : g_hist_ext
      assign hist_idx = {{(INDEX_BITS-HISTORY_BITS){1'b0}}, hist_r};
    end
  endgenerate

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign bidx_in    = in_beat.pc[INDEX_BITS-1:0];
  assign gidx_in    = bidx_in ^ hist_idx;
  assign hist_shift = {hist_r, taken_r};
  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;

  tbp_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_gshare_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (gidx_in),
    .rdata (g_rdata)
  );

  tbp_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_bimodal_chooser_ram (
    .clk   (clk),
    .we    (bc_we),
    .waddr (bc_waddr),
    .wdata (bc_wdata),
    .raddr (bidx_in),
    .rdata (bc_rdata)
  );

  assign g_pred = g_rdata[1];
  assign b_pred = bc_rdata[1];
  assign g_ok   = (g_pred == taken_r);
  assign b_ok   = (b_pred == taken_r);
  assign use_g  = bc_rdata[3];
  assign pred   = use_g ? g_pred : b_pred;
  assign ok     = (pred == taken_r);
  assign ch_new = (g_ok != b_ok) ? sat_update(bc_rdata[3:2], g_ok) : bc_rdata[3:2];

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    hist_nxt      = hist_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    g_we          = 1'b0;
    bc_we         = 1'b0;
    g_waddr       = gidx_r;
    bc_waddr      = bidx_r;
    g_wdata       = sat_update(g_rdata, taken_r);
    bc_wdata      = {ch_new, sat_update(bc_rdata[1:0], taken_r)};
    case (state_r)
      ST_CLEAR: begin
        g_we        = 1'b1;
        bc_we       = 1'b1;
        g_waddr     = clr_idx_r;
        bc_waddr    = clr_idx_r;
        g_wdata     = CTR_STRONG_TAKEN;
        bc_wdata    = {CHOOSER_STRONG_GSHARE, CTR_STRONG_TAKEN};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        g_we                            = 1'b1;
        bc_we                           = 1'b1;
        hist_nxt                        = hist_shift[HISTORY_BITS-1:0];
        hit_nxt                         = hit_r + {31'd0, ok};
        out_valid_nxt                   = 1'b1;
        out_beat_nxt.predicted_taken    = pred;
        out_beat_nxt.prediction_correct = ok;
        out_beat_nxt.used_gshare        = use_g;
        out_beat_nxt.correct_count      = hit_r + {31'd0, ok};
        state_nxt                       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hist_r      <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hist_r      <= hist_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
    if (accept) begin
      bidx_r  <= bidx_in;
      gidx_r  <= gidx_in;
      taken_r <= in_beat.taken;
    end
  end

endmodule
